[rtl/kil_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kil_pkg: shared definitions of the keyword and identifier lexer
// Token kinds, input modes, character codes, the token record and the
// bundle of results that one scan step hands to the output buffer.
// ----------------------------------------------------------------------------
package kil_pkg;

	// Default width of the line and column counters.
	localparam int unsigned KIL_POS_WIDTH = 16;

	// Longest identifier that is still accepted.
	localparam logic [7:0] MAX_IDENT_CHARS = 8'd255;

	// Saturation values of the integer literal and of reported positions.
	localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
	localparam int unsigned RPT_MAX = 65535;

	// Input item modes.
	typedef enum logic [1:0] {
		MODE_CHAR      = 2'd0,
		MODE_LINE_END  = 2'd1,
		MODE_INPUT_END = 2'd2
	} mode_t;

	// Token kinds.
	typedef enum logic [3:0] {
		KIND_LET    = 4'd0,
		KIND_PROC   = 4'd1,
		KIND_IDENT  = 4'd2,
		KIND_INT    = 4'd3,
		KIND_EQ     = 4'd4,
		KIND_LPAREN = 4'd5,
		KIND_RPAREN = 4'd6,
		KIND_LBRACE = 4'd7,
		KIND_RBRACE = 4'd8,
		KIND_SEMI   = 4'd9,
		KIND_EOF    = 4'd10,
		KIND_ERROR  = 4'd11
	} kind_t;

	// Character codes the scanner looks for.
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_LO_L   = 8'h6C;
	localparam logic [7:0] CH_LO_P   = 8'h70;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// One token as it leaves the block.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] line_no;
		logic [15:0] column_no;
		logic [30:0] int_value;
		logic [7:0]  ident_length;
	} tok_t;

	// Results of one scan step: up to two tokens, plus the halt status.
	typedef struct packed {
		logic [1:0] count;
		logic       halted;
		tok_t       first;
		tok_t       second;
	} scan_res_t;

	// Expected character of a keyword at a given match position.
	function automatic logic [7:0] kw_char(input logic is_let, input logic [1:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		if (is_let) begin
			case (idx)
				2'd0: ch = 8'h6C; // l
				2'd1: ch = 8'h65; // e
				default: ch = 8'h74; // t
			endcase
		end else begin
			case (idx)
				2'd0: ch = 8'h70; // p
				2'd1: ch = 8'h72; // r
				2'd2: ch = 8'h6F; // o
				default: ch = 8'h63; // c
			endcase
		end
		return ch;
	endfunction

endpackage

[rtl/kil_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kil_scan: lexer state and per-item scan logic
// Holds the scan phase, keyword progress, position counters, number and
// identifier accumulators and the halt flag. For the item presented it
// works out up to two tokens and the next state; the state is updated when
// the item is taken.
// ----------------------------------------------------------------------------
module kil_scan
	import kil_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = KIL_POS_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	output scan_res_t  res
);

	localparam int unsigned PW = POSITION_WIDTH;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_KW_LET,
		PH_KW_PROC,
		PH_IDENT,
		PH_INT,
		PH_SLASH,
		PH_COMMENT
	} phase_t;

	phase_t        phase_q, nx_phase;
	logic [1:0]    kp_q, nx_kp;
	logic [PW-1:0] line_q, nx_line;
	logic [PW-1:0] col_q, nx_col;
	logic [PW-1:0] tsc_q, nx_tsc;
	logic [30:0]   acc_q, nx_acc;
	logic [7:0]    tlen_q, nx_tlen;
	logic          halted_q, nx_halted;

	logic          a_v, b_v;
	tok_t          a_tok, b_tok;
	logic          do_flush, do_start;
	logic          is_alpha, is_digit, is_alnum, is_let;
	logic [7:0]    digit;
	logic [34:0]   acc_x10;
	logic [15:0]   line_rpt, tsc_rpt, col_rpt;

	// Saturating counter step.
	function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// 1-based position as reported, limited to the 16-bit port.
	function automatic logic [15:0] pos_report(input logic [PW-1:0] v);
		logic [PW-1:0] w;
		w = pos_inc(v);
		return (PW > 16 && w > PW'(RPT_MAX)) ? 16'hFFFF : 16'(w);
	endfunction

	// Character classes and the decimal accumulator step.
	always_comb begin
		is_alpha = (char_code >= CH_LO_A && char_code <= CH_LO_Z) ||
			(char_code >= CH_UP_A && char_code <= CH_UP_Z);
		is_digit = (char_code >= CH_ZERO && char_code <= CH_NINE);
		is_alnum = is_alpha || is_digit;
		is_let   = (phase_q == PH_KW_LET);
		digit    = char_code - CH_ZERO;
		acc_x10  = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(digit);
		line_rpt = pos_report(line_q);
		tsc_rpt  = pos_report(tsc_q);
		col_rpt  = pos_report(col_q);
	end

	// Next state and tokens for the presented item.
	always_comb begin
		nx_phase  = phase_q;
		nx_kp     = kp_q;
		nx_line   = line_q;
		nx_col    = col_q;
		nx_tsc    = tsc_q;
		nx_acc    = acc_q;
		nx_tlen   = tlen_q;
		nx_halted = halted_q;
		do_flush  = 1'b0;
		do_start  = 1'b0;
		a_v       = 1'b0;
		b_v       = 1'b0;
		b_tok     = '{kind: KIND_EOF, line_no: line_rpt, column_no: tsc_rpt,
			int_value: '0, ident_length: '0};

		// The pending token, as a flush would report it.
		a_tok = '{kind: KIND_IDENT, line_no: line_rpt, column_no: tsc_rpt,
			int_value: '0, ident_length: tlen_q};
		if (phase_q == PH_KW_LET || phase_q == PH_KW_PROC) begin
			a_tok.ident_length = {6'd0, kp_q};
		end else if (phase_q == PH_INT) begin
			a_tok.kind         = KIND_INT;
			a_tok.int_value    = acc_q;
			a_tok.ident_length = '0;
		end

		if (!halted_q) begin
			case (mode)
				MODE_CHAR: begin
					nx_col = pos_inc(col_q);
					case (phase_q)
						PH_SLASH: begin
							if (char_code == CH_SLASH) begin
								nx_phase = PH_COMMENT;
							end else begin
								do_start = 1'b1;
							end
						end
						PH_COMMENT: begin
							if (char_code == CH_LF) begin
								nx_phase = PH_IDLE;
							end
						end
						PH_KW_LET, PH_KW_PROC: begin
							if (char_code == kw_char(is_let, kp_q)) begin
								if (kp_q == (is_let ? 2'd2 : 2'd3)) begin
									b_v        = 1'b1;
									b_tok.kind = is_let ? KIND_LET : KIND_PROC;
									nx_phase   = PH_IDLE;
									nx_kp      = 2'd0;
								end else begin
									nx_kp = kp_q + 2'd1;
								end
							end else if (is_alnum) begin
								// Broken keyword continues as an identifier.
								nx_phase = PH_IDENT;
								nx_tlen  = {6'd0, kp_q} + 8'd1;
								nx_kp    = 2'd0;
							end else begin
								do_flush = 1'b1;
								do_start = 1'b1;
							end
						end
						PH_IDENT: begin
							if (is_alnum) begin
								if (tlen_q >= MAX_IDENT_CHARS) begin
									b_v        = 1'b1;
									b_tok.kind = KIND_ERROR;
									nx_halted  = 1'b1;
									nx_phase   = PH_IDLE;
									nx_tlen    = '0;
								end else begin
									nx_tlen = tlen_q + 8'd1;
								end
							end else begin
								do_flush = 1'b1;
								do_start = 1'b1;
							end
						end
						PH_INT: begin
							if (is_digit) begin
								nx_acc = (acc_x10 > 35'(INT_MAX31)) ? INT_MAX31 : acc_x10[30:0];
							end else begin
								do_flush = 1'b1;
								do_start = 1'b1;
							end
						end
						default: begin
							do_start = 1'b1;
						end
					endcase
				end
				MODE_LINE_END: begin
					do_flush = 1'b1;
					nx_line  = pos_inc(line_q);
					nx_col   = '0;
				end
				MODE_INPUT_END: begin
					do_flush        = 1'b1;
					b_v             = 1'b1;
					b_tok.kind      = KIND_EOF;
					b_tok.line_no   = 16'd1;
					b_tok.column_no = 16'd1;
					nx_line         = '0;
					nx_col          = '0;
					nx_tsc          = '0;
				end
				default: begin
				end
			endcase

			// Emit the pending token and return to idle.
			if (do_flush) begin
				a_v = (phase_q == PH_KW_LET) || (phase_q == PH_KW_PROC) ||
					(phase_q == PH_IDENT) || (phase_q == PH_INT);
				nx_phase = PH_IDLE;
				nx_kp    = '0;
				nx_tlen  = '0;
				nx_acc   = '0;
			end

			// Scan a character from the idle phase; it opens the next token.
			if (do_start) begin
				nx_tsc          = col_q;
				nx_phase        = PH_IDLE;
				b_tok.column_no = col_rpt;
				if (char_code == CH_SLASH) begin
					nx_phase = PH_SLASH;
				end else if (char_code == CH_LO_L) begin
					nx_phase = PH_KW_LET;
					nx_kp    = 2'd1;
				end else if (char_code == CH_LO_P) begin
					nx_phase = PH_KW_PROC;
					nx_kp    = 2'd1;
				end else if (is_alpha) begin
					nx_phase = PH_IDENT;
					nx_tlen  = 8'd1;
				end else if (is_digit) begin
					nx_phase = PH_INT;
					nx_acc   = 31'(digit);
				end else begin
					b_v = 1'b1;
					case (char_code)
						CH_EQ:     b_tok.kind = KIND_EQ;
						CH_LPAREN: b_tok.kind = KIND_LPAREN;
						CH_RPAREN: b_tok.kind = KIND_RPAREN;
						CH_LBRACE: b_tok.kind = KIND_LBRACE;
						CH_RBRACE: b_tok.kind = KIND_RBRACE;
						CH_SEMI:   b_tok.kind = KIND_SEMI;
						default:   b_v = 1'b0;
					endcase
				end
			end
		end
	end

	// Results: the flushed token always comes first.
	always_comb begin
		res.count  = {1'b0, a_v} + {1'b0, b_v};
		res.halted = halted_q;
		res.first  = a_v ? a_tok : b_tok;
		res.second = b_tok;
	end

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kp_q     <= '0;
			line_q   <= '0;
			col_q    <= '0;
			tsc_q    <= '0;
			acc_q    <= '0;
			tlen_q   <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			phase_q  <= nx_phase;
			kp_q     <= nx_kp;
			line_q   <= nx_line;
			col_q    <= nx_col;
			tsc_q    <= nx_tsc;
			acc_q    <= nx_acc;
			tlen_q   <= nx_tlen;
			halted_q <= nx_halted;
		end
	end

endmodule

[rtl/kil_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kil_out_buf: two-slot token output buffer
// Takes the tokens of one scan step at once and sends them one per
// transaction. It accepts a new load in the cycle its last token leaves.
// ----------------------------------------------------------------------------
module kil_out_buf
	import kil_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  scan_res_t res_in,
	output logic      can_load,
	input  logic      m_tready,
	output logic      m_tvalid,
	output tok_t      tok,
	output logic      last
);

	logic [1:0] cnt_q;
	tok_t       slot0_q, slot1_q;
	logic       send;

	// Handshake and load condition.
	always_comb begin
		m_tvalid = (cnt_q != 2'd0);
		send     = m_tvalid && m_tready;
		can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
		tok      = slot0_q;
		last     = (cnt_q == 2'd1);
	end

	// Slot fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_in.count;
		end else if (send) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Token slots; the second moves up after the first is sent.
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res_in.first;
			slot1_q <= res_in.second;
		end else if (send) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

[rtl/keyword_identifier_lexer.sv]
`timescale 1ns / 1ps
// A token is offered on the master side from the two-slot output buffer: its input
// item is first held in the input register, then its tokens are loaded into the buffer.
// Throughput: one input item per cycle while the output buffer can take its tokens;
// an item that yields two tokens fills the buffer, so a following one with tokens waits.
// A stalled receiver holds the input once the buffer cannot take the next load.
// Reset (arst_n low) returns the lexer to line 1, column 1 between tokens,
// clears the halt after an over-long identifier and empties the output buffer.
// ----------------------------------------------------------------------------
// keyword_identifier_lexer: streaming tokenizer for a small language
// Scans one source character per transaction, with line-end and input-end
// markers, and emits let/proc/identifier/integer/punctuation/eof/error tokens
// with their 1-based start line and column.
// ----------------------------------------------------------------------------
module keyword_identifier_lexer
	import kil_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = KIL_POS_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [15:0] line_no, [31:16] column_no,
	                              // [62:32] int_value, [70:63] ident_length, [71] zero
	output logic [3:0]  m_tuser,  // [3:0] kind
	output logic        m_tlast   // last token of its input item
);

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] char_s1;
	logic       step;
	logic       can_load;
	scan_res_t  res;
	tok_t       tok;

	// An item leaves the input register when its tokens fit in the buffer.
	always_comb begin
		step     = valid_s1 && (can_load || res.count == 2'd0);
		s_tready = !valid_s1 || step;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	kil_scan #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.mode     (mode_s1),
		.char_code(char_s1),
		.res      (res)
	);

	kil_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && res.count != 2'd0),
		.res_in  (res),
		.can_load(can_load),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.tok     (tok),
		.last    (m_tlast)
	);

	// Output packing.
	always_comb begin
		m_tuser = tok.kind;
		m_tdata = {1'b0, tok.ident_length, tok.int_value, tok.column_no, tok.line_no};
	end

	// Once halted, the lexer stays halted until reset.
	assert property (@(posedge clk) disable iff (!arst_n) res.halted |=> res.halted)
		else $error("lexer left the halted state without reset");

	// The first of two tokens from one item is never marked last.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && res.count == 2'd2 |=> m_tvalid && !m_tlast)
		else $error("first of a token pair marked last");

	// End of input closes its item and sits at line 1, column 1.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_EOF |-> m_tlast && m_tdata[15:0] == 16'd1 &&
		m_tdata[31:16] == 16'd1)
		else $error("eof token malformed");

	// A halted lexer produces no tokens.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(res.halted) && res.halted |-> !(step && res.count != 2'd0))
		else $error("token produced while halted");

endmodule

[sim/keyword_identifier_lexer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_identifier_lexer_checker: token predictor and scoreboard
// Watches both stream channels of the lexer. Each accepted input transaction
// runs a private model of the scanner, and the tokens it predicts are queued.
// Each accepted output transaction is compared field by field with the
// oldest queued token.
// ----------------------------------------------------------------------------
module keyword_identifier_lexer_checker
	import kil_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic [1:0]  s_tuser,  // [1:0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,  // [15:0] line_no, [31:16] column_no,
	                              // [62:32] int_value, [70:63] ident_length, [71] zero
	input  logic [3:0]  m_tuser,  // [3:0] kind
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_count
);

	localparam int unsigned POS_LIMIT = (1 << KIL_POS_WIDTH) - 1;
	localparam longint unsigned INT_LIMIT = 64'h7FFF_FFFF;
	localparam logic [23:0] LET_TEXT = "let";
	localparam logic [31:0] PROC_TEXT = "proc";

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_LET,
		SCAN_PROC,
		SCAN_IDENT,
		SCAN_INT,
		SCAN_SLASH,
		SCAN_COMMENT
	} scan_phase_t;

	typedef struct {
		kind_t       kind;
		logic [15:0] line_no;
		logic [15:0] column_no;
		logic [30:0] int_value;
		logic [7:0]  ident_length;
		logic        is_last;
	} token_t;

	// Private copy of the scanner state.
	scan_phase_t     phase;
	int unsigned     kw_pos;
	int unsigned     line_pos;
	int unsigned     col_pos;
	int unsigned     tok_col;
	int unsigned     id_len;
	longint unsigned num_acc;
	bit              halted;

	token_t step_tokens[$];
	token_t expected_tokens[$];
	token_t want_tok;
	int     errors;

	function automatic int unsigned bump(int unsigned v);
		return (v >= POS_LIMIT) ? POS_LIMIT : v + 1;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function void reset_scanner();
		phase = SCAN_IDLE;
		kw_pos = 0;
		line_pos = 0;
		col_pos = 0;
		tok_col = 0;
		num_acc = 0;
		id_len = 0;
		halted = 1'b0;
	endfunction

	// A step reports at most two tokens; anything beyond is dropped.
	function void add_token(kind_t k, int unsigned ln, int unsigned cl,
			longint unsigned v, int unsigned n);
		token_t t;
		if (step_tokens.size() < 2) begin
			t.kind = k;
			t.line_no = ln[15:0];
			t.column_no = cl[15:0];
			t.int_value = v[30:0];
			t.ident_length = n[7:0];
			t.is_last = 1'b0;
			step_tokens.push_back(t);
		end
	endfunction

	function void token_at_start(kind_t k, longint unsigned v, int unsigned n);
		add_token(k, bump(line_pos), bump(tok_col), v, n);
	endfunction

	// Emit the token under construction, if any, and go back to idle.
	function void flush_pending();
		case (phase)
			SCAN_LET, SCAN_PROC: token_at_start(KIND_IDENT, 0, kw_pos);
			SCAN_IDENT:          token_at_start(KIND_IDENT, 0, id_len);
			SCAN_INT:            token_at_start(KIND_INT, num_acc, 0);
			default: ;
		endcase
		phase = SCAN_IDLE;
		kw_pos = 0;
		id_len = 0;
		num_acc = 0;
	endfunction

	// A byte seen between tokens.
	function void start_token(logic [7:0] c, int unsigned cl);
		tok_col = cl;
		if (c == CH_SLASH) begin
			phase = SCAN_SLASH;
		end else if (c == CH_LO_L) begin
			phase = SCAN_LET;
			kw_pos = 1;
		end else if (c == CH_LO_P) begin
			phase = SCAN_PROC;
			kw_pos = 1;
		end else if (is_letter(c)) begin
			phase = SCAN_IDENT;
			id_len = 1;
		end else if (is_digit(c)) begin
			phase = SCAN_INT;
			num_acc = c - CH_ZERO;
		end else begin
			case (c)
				CH_EQ:     token_at_start(KIND_EQ, 0, 0);
				CH_LPAREN: token_at_start(KIND_LPAREN, 0, 0);
				CH_RPAREN: token_at_start(KIND_RPAREN, 0, 0);
				CH_LBRACE: token_at_start(KIND_LBRACE, 0, 0);
				CH_RBRACE: token_at_start(KIND_RBRACE, 0, 0);
				CH_SEMI:   token_at_start(KIND_SEMI, 0, 0);
				default: ;
			endcase
		end
	endfunction

	// A byte inside an identifier; an over-long one halts the scanner.
	function void ident_char(logic [7:0] c, int unsigned cl);
		if (is_letter(c) || is_digit(c)) begin
			if (id_len >= MAX_IDENT_CHARS) begin
				token_at_start(KIND_ERROR, 0, 0);
				halted = 1'b1;
				phase = SCAN_IDLE;
				id_len = 0;
			end else begin
				id_len++;
			end
		end else begin
			flush_pending();
			start_token(c, cl);
		end
	endfunction

	function void scan_char(logic [7:0] c, int unsigned cl);
		bit              is_let;
		int unsigned     klen;
		int unsigned     p;
		logic [7:0]      want;
		longint unsigned next_val;
		case (phase)
			SCAN_SLASH: begin
				if (c == CH_SLASH) begin
					phase = SCAN_COMMENT;
				end else begin
					phase = SCAN_IDLE;
					start_token(c, cl);
				end
			end
			SCAN_COMMENT: begin
				if (c == CH_LF)
					phase = SCAN_IDLE;
			end
			SCAN_LET, SCAN_PROC: begin
				is_let = (phase == SCAN_LET);
				klen = is_let ? 3 : 4;
				p = (kw_pos < klen) ? kw_pos : klen - 1;
				if (is_let)
					want = LET_TEXT[23 - 8 * p -: 8];
				else
					want = PROC_TEXT[31 - 8 * p -: 8];
				if (c == want) begin
					kw_pos = p + 1;
					if (kw_pos >= klen) begin
						token_at_start(is_let ? KIND_LET : KIND_PROC, 0, 0);
						phase = SCAN_IDLE;
						kw_pos = 0;
					end
				end else begin
					// The partial keyword becomes the head of an identifier.
					phase = SCAN_IDENT;
					id_len = p;
					kw_pos = 0;
					ident_char(c, cl);
				end
			end
			SCAN_IDENT: ident_char(c, cl);
			SCAN_INT: begin
				if (is_digit(c)) begin
					next_val = num_acc * 10 + (c - CH_ZERO);
					num_acc = (next_val > INT_LIMIT) ? INT_LIMIT : next_val;
				end else begin
					flush_pending();
					start_token(c, cl);
				end
			end
			default: begin
				phase = SCAN_IDLE;
				start_token(c, cl);
			end
		endcase
	endfunction

	// Predict the tokens of one input transaction and queue them.
	function void lex_step(logic [1:0] md, logic [7:0] c);
		int unsigned cl;
		step_tokens.delete();
		if (!halted) begin
			case (md)
				MODE_CHAR: begin
					cl = col_pos;
					col_pos = bump(col_pos);
					scan_char(c, cl);
				end
				MODE_LINE_END: begin
					flush_pending();
					line_pos = bump(line_pos);
					col_pos = 0;
				end
				MODE_INPUT_END: begin
					flush_pending();
					add_token(KIND_EOF, 1, 1, 0, 0);
					line_pos = 0;
					col_pos = 0;
					tok_col = 0;
				end
				default: ;
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].is_last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	// Scoreboard: compare outputs first, then predict from the accepted input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_scanner();
			expected_tokens.delete();
			errors = 0;
			pending_count <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected token kind %0d line %0d col %0d",
							$realtime, m_tuser, m_tdata[15:0], m_tdata[31:16]);
				end else begin
					want_tok = expected_tokens.pop_front();
					if (m_tuser !== want_tok.kind || m_tdata[15:0] !== want_tok.line_no ||
							m_tdata[31:16] !== want_tok.column_no ||
							m_tdata[62:32] !== want_tok.int_value ||
							m_tdata[70:63] !== want_tok.ident_length ||
							m_tlast !== want_tok.is_last) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: expected kind %0d line %0d col %0d int %0d len %0d last %0b",
								$realtime, want_tok.kind, want_tok.line_no, want_tok.column_no,
								want_tok.int_value, want_tok.ident_length, want_tok.is_last);
							$display("%0t: actual   kind %0d line %0d col %0d int %0d len %0d last %0b",
								$realtime, m_tuser, m_tdata[15:0], m_tdata[31:16],
								m_tdata[62:32], m_tdata[70:63], m_tlast);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				lex_step(s_tuser, s_tdata);
			pending_count <= expected_tokens.size();
			fail_count <= errors;
		end
	end

endmodule

[sim/keyword_identifier_lexer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_identifier_lexer_test: stimulus and verdict for the lexer
// Drives a directed source fragment, then random token sequences under
// several idle and stall patterns and finally an over-long identifier that
// halts the lexer. A checker beside the DUT predicts and compares every token.
// ----------------------------------------------------------------------------
module keyword_identifier_lexer_test;
	import kil_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 200000;
	localparam int PHASE_ITEMS = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending_count;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	always #5 clk = ~clk;

	keyword_identifier_lexer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	keyword_identifier_lexer_checker token_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(51);
		return (r < 26) ? 8'(CH_LO_A + r) : 8'(CH_UP_A + (r - 26));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(61) < 10) ? 8'(CH_ZERO + $urandom_range(9)) : rand_letter();
	endfunction

	// One input transaction, after a random number of idle cycles.
	task automatic send_item(input logic [1:0] md, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= md;
		s_tdata <= ch;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (md != MODE_UNUSED)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(MODE_CHAR, s[i]);
	endtask

	// Stop offering and wait until every predicted token has come out.
	task automatic wait_drained();
		int cycles;
		cycles = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0 && cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
	endtask

	// One fragment of source: mostly well-formed tokens, some noise.
	task automatic send_random_phrase();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 10) begin
			send_text("let");
			if ($urandom_range(1))
				send_item(MODE_CHAR, rand_alnum());
		end else if (pick < 17) begin
			send_text("proc");
			if ($urandom_range(1))
				send_item(MODE_CHAR, rand_alnum());
		end else if (pick < 22) begin
			// Keyword broken off part way.
			case ($urandom_range(4))
				0: send_text("l");
				1: send_text("le");
				2: send_text("p");
				3: send_text("pr");
				default: send_text("pro");
			endcase
			send_item(MODE_CHAR, $urandom_range(1) ? rand_alnum() : 8'($urandom_range(255)));
		end else if (pick < 37) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 9);
			send_item(MODE_CHAR, rand_letter());
			repeat (n)
				send_item(MODE_CHAR, rand_alnum());
			if ($urandom_range(1))
				send_item(MODE_CHAR, CH_SPACE);
		end else if (pick < 50) begin
			// Long digit runs saturate the literal.
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
			repeat (n)
				send_item(MODE_CHAR, 8'(CH_ZERO + $urandom_range(9)));
			if ($urandom_range(1))
				send_item(MODE_CHAR, CH_SPACE);
		end else if (pick < 62) begin
			case ($urandom_range(5))
				0: send_item(MODE_CHAR, CH_EQ);
				1: send_item(MODE_CHAR, CH_LPAREN);
				2: send_item(MODE_CHAR, CH_RPAREN);
				3: send_item(MODE_CHAR, CH_LBRACE);
				4: send_item(MODE_CHAR, CH_RBRACE);
				default: send_item(MODE_CHAR, CH_SEMI);
			endcase
		end else if (pick < 71) begin
			case ($urandom_range(2))
				0: send_item(MODE_CHAR, CH_SPACE);
				1: send_item(MODE_CHAR, CH_TAB);
				default: send_item(MODE_CHAR, CH_LF);
			endcase
		end else if (pick < 76) begin
			// Comment with random body, closed by a line end or by the byte 10.
			send_text("//");
			repeat ($urandom_range(8))
				send_item(MODE_CHAR, 8'($urandom_range(255)));
			if ($urandom_range(1))
				send_item(MODE_LINE_END, 8'($urandom_range(255)));
			else
				send_item(MODE_CHAR, CH_LF);
		end else if (pick < 79) begin
			send_item(MODE_CHAR, CH_SLASH);
			send_item(MODE_CHAR, 8'($urandom_range(255)));
		end else if (pick < 87) begin
			send_item(MODE_LINE_END, 8'($urandom_range(255)));
		end else if (pick < 89) begin
			send_item(MODE_INPUT_END, 8'($urandom_range(255)));
		end else if (pick < 96) begin
			send_item(MODE_CHAR, 8'($urandom_range(255)));
		end else begin
			send_item(MODE_UNUSED, 8'($urandom_range(255)));
		end
	endtask

	// Random traffic under one idle/stall pattern, then a full drain.
	task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
		int goal;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		goal = items_sent + PHASE_ITEMS;
		if (with_hold)
			hold_requests <= hold_requests + 1;
		while (items_sent < goal)
			send_random_phrase();
		wait_drained();
	endtask

	// Main sequence.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed fragment: every token kind but error, lone slash, both comment ends,
		// zero and top bytes, the unused mode and end of input.
		send_text("letprocq9=(){};");
		send_text("/a");
		send_item(MODE_CHAR, 8'h00);
		send_item(MODE_CHAR, 8'hFF);
		send_text("//x");
		send_item(MODE_CHAR, CH_LF);
		send_text("7");
		send_item(MODE_LINE_END, 8'h00);
		send_text("//;");
		send_item(MODE_LINE_END, 8'hFF);
		send_item(MODE_UNUSED, 8'h5A);
		send_item(MODE_INPUT_END, 8'h00);
		wait_drained();

		run_phase(0, 0, 1'b1);
		run_phase(72, 0, 1'b0);
		run_phase(0, 72, 1'b1);
		run_phase(31, 31, 1'b0);

		// Longest legal identifier, then one that is too long and halts the lexer.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(MODE_CHAR, "z");
		repeat (254)
			send_item(MODE_CHAR, rand_alnum());
		send_item(MODE_CHAR, CH_SPACE);
		send_item(MODE_CHAR, "A");
		repeat (255)
			send_item(MODE_CHAR, rand_alnum());
		send_text("let;");
		send_item(MODE_LINE_END, 8'h00);
		send_item(MODE_INPUT_END, 8'h00);
		wait_drained();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
